// ----- rtl/ambpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ambpm_pkg
// shared types and constants of the audio buffer pool manager
// ----------------------------------------------------------------------------
package ambpm_pkg;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned NEXT_W      = 4;
  localparam int unsigned AVAIL_W     = 12;
  localparam int unsigned WPB_W       = 9;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [2:0] {
    MODE_START      = 3'd0,
    MODE_USER_WRITE = 3'd1,
    MODE_USER_READ  = 3'd2,
    MODE_PORT_WORD  = 3'd3,
    MODE_BUF_DONE   = 3'd4,
    MODE_TAKE_FLAG  = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IS_OUTPUT   = 2'd0,
    CFG_WORDS_PER   = 2'd1,
    CFG_SILENCE     = 2'd2
  } cfg_idx_e;

  // source of the read data of a result
  typedef enum logic [1:0] {
    SRC_ZERO    = 2'd0,
    SRC_MEM     = 2'd1,
    SRC_SILENCE = 2'd2
  } rd_src_e;

endpackage : ambpm_pkg
`default_nettype wire

// ----- rtl/audio_multibuffer_pool_manager.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// audio_multibuffer_pool_manager
// pool of audio buffers cycling between an empty queue, a filled queue and
// the active pair used by the port side
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle unless the clearing sweep or a
// stalled output holds it back. All queue, pointer and offset updates of a
// transaction happen at the edge it is accepted, with its single sample store
// access; the result goes from the stage-1 registers to the output register.
// After reset the store is zeroed one word a cycle, over all BUFFERS*MAX_WORDS
// words (2048 by default); s_axis_tready stays low, config writes are taken.
module audio_multibuffer_pool_manager
  import ambpm_pkg::*;
#(
  parameter int unsigned BUFFERS   = 8,
  parameter int unsigned MAX_WORDS = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [DATA_W-1:0]      cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // mode[2:0], data[34:3], zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // ok[0], read_data[32:1], next_buffer[36:33], flow_flag[37],
  // words_available[49:38], zero fill
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned DEPTH = BUFFERS * MAX_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned HW    = $clog2(BUFFERS);
  localparam int unsigned BW    = $clog2(BUFFERS + 1);
  localparam int unsigned CNW   = $clog2(BUFFERS + 1);
  localparam int unsigned OW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned LW    = $clog2(MAX_WORDS + 1);
  localparam int unsigned LCW   = (LW > WPB_W) ? LW : WPB_W;
  localparam int unsigned CMPW  = LCW + 1;
  localparam int unsigned PW    = CNW + LCW + 1;
  localparam int unsigned WLW   = (PW > AVAIL_W) ? PW : AVAIL_W;

  function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] a,
                                             input logic [CNW-1:0] n);
    logic [CNW:0] s;
    s = (CNW+1)'(a) + (CNW+1)'(n);
    if (s >= (CNW+1)'(BUFFERS)) s = s - (CNW+1)'(BUFFERS);
    return s[HW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [HW-1:0] b,
                                            input logic [OW-1:0] off);
    return AW'(b) * AW'(MAX_WORDS) + AW'(off);
  endfunction

  // configuration
  logic              is_out_q;
  logic [WPB_W-1:0]  wpb_q;
  logic [DATA_W-1:0] sil_q;

  // pool state
  logic [HW-1:0]  eq_q [BUFFERS];
  logic [HW-1:0]  fq_q [BUFFERS];
  logic [HW-1:0]  ehead_q, ehead_d, fhead_q, fhead_d;
  logic [CNW-1:0] ecnt_q, ecnt_d, fcnt_q, fcnt_d;
  logic [BW-1:0]  a0_q, a0_d, a1_q, a1_d;
  logic [OW-1:0]  uoff_q, uoff_d, poff_q, poff_d;
  logic           running_q, running_d, flow_q, flow_d;

  // clearing sweep
  logic           clr_q;
  logic [AW-1:0]  clr_addr_q;

  // pipeline
  logic              s1_valid_q, s1_ok_q, s1_flag_q, s1_ok_d, s1_flag_d;
  rd_src_e           s1_src_q, s1_src_d;
  logic [NEXT_W-1:0] s1_next_q, s1_next_d;
  logic [DATA_W-1:0] mem_q;
  logic              m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic [DATA_W-1:0] mem [DEPTH];

  mode_e             in_mode;
  logic [DATA_W-1:0] in_data;
  logic              acc, adv1;
  logic [LCW-1:0]    len_c;
  logic [WPB_W-1:0]  wpb_tmp;
  logic [LCW-1:0]    wpb_x;

  logic [HW-1:0]  efront, esecond, ffront, epos, fpos;
  logic [1:0]     e_pop;
  logic           f_pop, e_push, f_push, e_push_ok, f_push_ok;
  logic [HW-1:0]  e_push_val, f_push_val;
  logic           a0_valid, a1_valid;

  logic           it_re, it_wr;
  logic [HW-1:0]  it_b;
  logic [OW-1:0]  it_off;
  logic [CMPW-1:0] uinc, pinc;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [BW+NEXT_W-1:0] next_ext;

  logic [CNW-1:0]    qcnt;
  logic [WLW-1:0]    wl_rem, wl_prod, wl_sum;
  logic [AVAIL_W-1:0] words_now;
  logic [DATA_W-1:0] rd_sel;

  assign in_mode = mode_e'(s_axis_tdata[2:0]);
  assign in_data = s_axis_tdata[34:3];

  assign adv1          = s1_valid_q & (~m_valid_q | m_axis_tready);
  assign s_axis_tready = ~clr_q & (~s1_valid_q | adv1);
  assign acc           = s_axis_tvalid & s_axis_tready;

  // effective buffer length
  always_comb begin
    wpb_tmp = wpb_q;
    wpb_x   = LCW'(wpb_tmp);
    if (wpb_q == '0) begin
      len_c = LCW'(1);
    end else if (wpb_x > LCW'(MAX_WORDS)) begin
      len_c = LCW'(MAX_WORDS);
    end else begin
      len_c = wpb_x;
    end
  end

  assign efront   = eq_q[ehead_q];
  assign esecond  = eq_q[wrap_add(ehead_q, CNW'(1))];
  assign ffront   = fq_q[fhead_q];
  assign epos     = wrap_add(ehead_q, ecnt_q);
  assign fpos     = wrap_add(fhead_q, fcnt_q);
  assign a0_valid = a0_q < BW'(BUFFERS);
  assign a1_valid = a1_q < BW'(BUFFERS);
  assign uinc     = CMPW'(uoff_q) + CMPW'(1);
  assign pinc     = CMPW'(poff_q) + CMPW'(1);

  always_comb begin
    running_d  = running_q;
    flow_d     = flow_q;
    a0_d       = a0_q;
    a1_d       = a1_q;
    uoff_d     = uoff_q;
    poff_d     = poff_q;
    e_pop      = 2'd0;
    f_pop      = 1'b0;
    e_push     = 1'b0;
    f_push     = 1'b0;
    e_push_val = efront;
    f_push_val = efront;
    it_re      = 1'b0;
    it_wr      = 1'b0;
    it_b       = efront;
    it_off     = uoff_q;
    s1_ok_d    = 1'b0;
    s1_flag_d  = 1'b0;
    s1_src_d   = SRC_ZERO;
    s1_next_d  = '0;
    next_ext   = '0;
    if (acc) begin
      unique case (in_mode)
        MODE_START: begin
          if (!running_q) begin
            running_d = 1'b1;
            if (!is_out_q) begin
              a0_d = (ecnt_q > CNW'(0)) ? BW'(efront) : BW'(BUFFERS);
              a1_d = (ecnt_q > CNW'(1)) ? BW'(esecond) : BW'(BUFFERS);
              e_pop = (ecnt_q > CNW'(1)) ? 2'd2 : ((ecnt_q > CNW'(0)) ? 2'd1 : 2'd0);
            end
            poff_d  = '0;
            s1_ok_d = 1'b1;
          end
        end
        MODE_USER_WRITE: begin
          if (running_q && is_out_q && ecnt_q != '0) begin
            it_wr  = 1'b1;
            it_b   = efront;
            it_off = uoff_q;
            if (uinc >= CMPW'(len_c)) begin
              e_pop      = 2'd1;
              f_push     = 1'b1;
              f_push_val = efront;
              uoff_d     = '0;
            end else begin
              uoff_d = uinc[OW-1:0];
            end
            s1_ok_d = 1'b1;
          end
        end
        MODE_USER_READ: begin
          if (running_q && !is_out_q && fcnt_q != '0) begin
            it_re    = 1'b1;
            it_b     = ffront;
            it_off   = uoff_q;
            s1_src_d = SRC_MEM;
            if (uinc >= CMPW'(len_c)) begin
              f_pop      = 1'b1;
              e_push     = 1'b1;
              e_push_val = ffront;
              uoff_d     = '0;
            end else begin
              uoff_d = uinc[OW-1:0];
            end
            s1_ok_d = 1'b1;
          end
        end
        MODE_PORT_WORD: begin
          if (running_q && (is_out_q || a0_valid)) begin
            it_b   = a0_q[HW-1:0];
            it_off = poff_q;
            if (is_out_q) begin
              if (a0_valid) begin
                it_re    = 1'b1;
                s1_src_d = SRC_MEM;
              end else begin
                s1_src_d = SRC_SILENCE;
              end
            end else begin
              it_wr = 1'b1;
            end
            poff_d  = (pinc >= CMPW'(len_c)) ? '0 : pinc[OW-1:0];
            s1_ok_d = 1'b1;
          end
        end
        MODE_BUF_DONE: begin
          if (running_q) begin
            if (is_out_q) begin
              e_push     = a0_valid;
              e_push_val = a0_q[HW-1:0];
              a0_d       = a1_q;
              if (fcnt_q != '0) begin
                a1_d  = BW'(ffront);
                f_pop = 1'b1;
              end else begin
                a1_d   = BW'(BUFFERS);
                flow_d = 1'b1;
              end
            end else if (ecnt_q != '0) begin
              f_push     = a0_valid;
              f_push_val = a0_q[HW-1:0];
              a0_d       = a1_q;
              a1_d       = BW'(efront);
              e_pop      = 2'd1;
            end else begin
              flow_d = 1'b1;
            end
            poff_d    = '0;
            next_ext  = (BW+NEXT_W)'(a1_d);
            s1_next_d = next_ext[NEXT_W-1:0];
            s1_ok_d   = 1'b1;
          end
        end
        MODE_TAKE_FLAG: begin
          s1_flag_d = flow_q;
          flow_d    = 1'b0;
          s1_ok_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign e_push_ok = e_push & (ecnt_q < CNW'(BUFFERS));
  assign f_push_ok = f_push & (fcnt_q < CNW'(BUFFERS));

  always_comb begin
    ehead_d = wrap_add(ehead_q, CNW'(e_pop));
    fhead_d = wrap_add(fhead_q, CNW'(f_pop));
    ecnt_d  = ecnt_q - CNW'(e_pop) + CNW'(e_push_ok);
    fcnt_d  = fcnt_q - CNW'(f_pop) + CNW'(f_push_ok);
  end

  // store access
  assign mem_we    = clr_q | (acc & it_wr);
  assign mem_addr  = clr_q ? clr_addr_q : addr_of(it_b, it_off);
  assign mem_wdata = clr_q ? '0 : in_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (acc & it_re) begin
      mem_q <= mem[mem_addr];
    end
  end

  // words left for the user, from the state after the transaction in stage 1
  always_comb begin
    qcnt    = is_out_q ? ecnt_q : fcnt_q;
    wl_rem  = (CMPW'(uoff_q) < CMPW'(len_c)) ? (WLW'(len_c) - WLW'(uoff_q)) : '0;
    wl_prod = WLW'(qcnt - CNW'(1)) * WLW'(len_c);
    wl_sum  = wl_rem + wl_prod;
    if (!running_q || qcnt == '0) begin
      words_now = '0;
    end else begin
      words_now = wl_sum[AVAIL_W-1:0];
    end
  end

  always_comb begin
    unique case (s1_src_q)
      SRC_MEM:     rd_sel = mem_q;
      SRC_SILENCE: rd_sel = sil_q;
      default:     rd_sel = '0;
    endcase
    m_data_d = {6'b0, words_now, s1_flag_q, s1_next_q, rd_sel, s1_ok_q};
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ok_q   <= s1_ok_d;
      s1_flag_q <= s1_flag_d;
      s1_src_q  <= s1_src_d;
      s1_next_q <= s1_next_d;
    end
    if (adv1) begin
      m_data_q <= m_data_d;
    end
    if (acc && f_push_ok) begin
      fq_q[fpos] <= f_push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_out_q   <= 1'b1;
      wpb_q      <= WPB_W'(256);
      sil_q      <= '0;
      for (int i = 0; i < BUFFERS; i++) begin
        eq_q[i] <= HW'(i);
      end
      ehead_q    <= '0;
      ecnt_q     <= CNW'(BUFFERS);
      fhead_q    <= '0;
      fcnt_q     <= '0;
      a0_q       <= BW'(BUFFERS);
      a1_q       <= BW'(BUFFERS);
      uoff_q     <= '0;
      poff_q     <= '0;
      running_q  <= 1'b0;
      flow_q     <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_IS_OUTPUT: is_out_q <= cfg_data_i[0];
          CFG_WORDS_PER: wpb_q    <= cfg_data_i[WPB_W-1:0];
          CFG_SILENCE:   sil_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (acc) begin
        if (e_push_ok) begin
          eq_q[epos] <= e_push_val;
        end
        ehead_q   <= ehead_d;
        ecnt_q    <= ecnt_d;
        fhead_q   <= fhead_d;
        fcnt_q    <= fcnt_d;
        a0_q      <= a0_d;
        a1_q      <= a1_d;
        uoff_q    <= uoff_d;
        poff_q    <= poff_d;
        running_q <= running_d;
        flow_q    <= flow_d;
      end
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // the queue counts and the valid active pair entries always add up to BUFFERS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNW+2)'(ecnt_q) + (CNW+2)'(fcnt_q) + (CNW+2)'(a0_valid) + (CNW+2)'(a1_valid))
      == (CNW+2)'(BUFFERS))
    else $error("buffer pool lost or duplicated a buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && m_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("transaction taken while both stages are stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_mode == MODE_BUF_DONE && running_q) |=> (poff_q == '0))
    else $error("port offset not rewound after buffer done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> ($past(clr_addr_q) == AW'(DEPTH - 1)))
    else $error("clearing sweep ended early");
`endif

endmodule : audio_multibuffer_pool_manager
`default_nettype wire
